// File: rtl/krs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_pkg: shared constants and codes for the keyed record store
// Capacity, index and count widths, request kinds and status codes.
// ----------------------------------------------------------------------------
package krs_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 8;
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = KEY_W + DATA_W;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_STORE  = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_INSERTED    = 3'd0,
        STAT_OVERWRITTEN = 3'd1,
        STAT_DELETED     = 3'd2,
        STAT_READ_OK     = 3'd3,
        STAT_NOT_FOUND   = 3'd4,
        STAT_FULL        = 3'd5
    } status_t;

endpackage

// File: rtl/krs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module krs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/keyed_record_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_store: small associative table of 8-bit keys and 32-bit data
// Store, delete and read requests by key, one status result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request per transfer (kind, key, payload).
//   Result channel m_*: one result per request (status, read_data,
//   entry_count), in request order.
//   Keys and data live in one synchronous RAM; valid bits and the record
//   count live in flip-flops. A request walks the RAM one slot per cycle
//   looking for its key and stops at the first match, then writes back.
//   A result is loaded into the output register at write-back, after the
//   scan (one RAM read per slot scanned, then the write-back state). The
//   next request is taken only once the block is back in idle, after the
//   result is loaded, so a request is finished before the next is taken.
//   s_ready is high only while no request is in progress. A finished result
//   waits in the output register; while the receiver stalls, one more
//   request is taken and scanned, then holds at write-back until the
//   output register frees.
//   Reset clears all valid bits, the count and the output valid; key and
//   data slots need no clearing as they are read only once written.
// ----------------------------------------------------------------------------
module keyed_record_store (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_key,
    input  logic [31:0] s_payload,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_read_data,
    output logic [6:0]  m_entry_count
);

    localparam int IDX_W   = krs_pkg::IDX_W;
    localparam int CNT_W   = krs_pkg::CNT_W;
    localparam int KEY_W   = krs_pkg::KEY_W;
    localparam int DATA_W  = krs_pkg::DATA_W;
    localparam int ENTRY_W = krs_pkg::ENTRY_W;
    localparam int CAP     = krs_pkg::CAPACITY;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // request holding registers
    logic [1:0]        kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] payload_reg;

    // scan progress and match result
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [DATA_W-1:0] hit_data_reg, hit_data_next;

    // table status
    logic [CAP-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_read_data_reg, m_read_data_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    // RAM ports
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    // lowest free slot
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;

    logic              accept;
    logic              out_free;
    logic              slot_match;

    krs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAP)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Compare the slot whose read data is on the RAM output
    assign slot_match = valid_reg[scan_idx_reg]
                     && (ram_rd_data[ENTRY_W-1:DATA_W] == key_reg);

    // Read slot zero while idle, then the next slot each scan cycle
    assign ram_rd_addr = (state_reg == ST_SCAN) ? (scan_idx_reg + IDX_W'(1)) : '0;

    // Find the lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Sequence scan and write-back
    always_comb begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_data_next    = hit_data_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_read_data_next = m_read_data_reg;
        m_count_next     = m_count_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = hit_idx_reg;
        ram_wr_data      = {key_reg, payload_reg};

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (slot_match) begin
                    hit_next      = 1'b1;
                    hit_idx_next  = scan_idx_reg;
                    hit_data_next = ram_rd_data[DATA_W-1:0];
                    state_next    = ST_FINISH;
                end else if (scan_idx_reg == IDX_W'(CAP - 1)) begin
                    state_next    = ST_FINISH;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_read_data_next = '0;
                    m_status_next    = krs_pkg::STAT_NOT_FOUND;
                    unique case (kind_reg)
                        krs_pkg::KIND_STORE: begin
                            if (hit_reg) begin
                                ram_wr_en     = 1'b1;
                                ram_wr_addr   = hit_idx_reg;
                                m_status_next = krs_pkg::STAT_OVERWRITTEN;
                            end else if (free_found) begin
                                ram_wr_en            = 1'b1;
                                ram_wr_addr          = free_idx;
                                valid_next[free_idx] = 1'b1;
                                count_next           = count_reg + CNT_W'(1);
                                m_status_next        = krs_pkg::STAT_INSERTED;
                            end else begin
                                m_status_next = krs_pkg::STAT_FULL;
                            end
                        end
                        krs_pkg::KIND_DELETE: begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg] = 1'b0;
                                if (count_reg != '0) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                                m_status_next = krs_pkg::STAT_DELETED;
                            end
                        end
                        krs_pkg::KIND_READ: begin
                            if (hit_reg) begin
                                m_read_data_next = hit_data_reg;
                                m_status_next    = krs_pkg::STAT_READ_OK;
                            end
                        end
                        default: begin
                            m_status_next = krs_pkg::STAT_NOT_FOUND;
                        end
                    endcase
                    m_count_next = count_next;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload, scan and output data registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg    <= s_kind;
            key_reg     <= s_key;
            payload_reg <= s_payload;
        end
        scan_idx_reg    <= scan_idx_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        hit_data_reg    <= hit_data_next;
        m_status_reg    <= m_status_next;
        m_read_data_reg <= m_read_data_next;
        m_count_reg     <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_entry_count = 7'(m_count_reg);

endmodule
